@@ hw/rtl/mdr_pkg.sv @@
// Shared types and constants for the rescaling pipeline.
package mdr_pkg;
  localparam int VAL_W = 64;
  localparam int CFG_W = 63;
  localparam int MODE_W = 3;
  localparam int PROD_W = 128;

  localparam logic [MODE_W-1:0] MODE_NEAREST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRUNC   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AWAY    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLOOR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CEIL    = 3'd4;

  localparam logic [1:0] REG_MULT = 2'd0;
  localparam logic [1:0] REG_DIV  = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  // Item context carried alongside the arithmetic through every stage.
  typedef struct packed {
    logic neg;
    logic err;
  } ctx_t;
endpackage

@@ hw/rtl/mdr_mul.sv @@
// Pipelined 64x63 magnitude multiplier built from 32-bit partial products.
module mdr_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [mdr_pkg::VAL_W-1:0]    mag,
  input  logic [mdr_pkg::CFG_W-1:0]    mult,
  input  mdr_pkg::ctx_t                in_ctx,
  output logic                         out_v,
  output logic [mdr_pkg::PROD_W-1:0]   prod,
  output mdr_pkg::ctx_t                out_ctx
);
  logic [63:0] p0_r, p1_r, p2_r, p3_r;
  logic        v1_r;
  mdr_pkg::ctx_t c1_r;
  logic [63:0] bm;
  assign bm = {1'b0, mult};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1_r  <= in_v;
      out_v <= v1_r;
    end
    if (en) begin
      p0_r <= mag[31:0]  * bm[31:0];
      p1_r <= mag[63:32] * bm[31:0];
      p2_r <= mag[31:0]  * bm[63:32];
      p3_r <= mag[63:32] * bm[63:32];
      c1_r <= in_ctx;
      prod <= {p3_r, p0_r} + {32'd0, p1_r, 32'd0} + {32'd0, p2_r, 32'd0};
      out_ctx <= c1_r;
    end
  end
endmodule

@@ hw/rtl/mdr_div_stage.sv @@
// One restoring-division step of the divider pipeline, registered.
module mdr_div_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [63:0]               rem_i,
  input  logic [63:0]               lo_i,
  input  logic [63:0]               q_i,
  input  logic [mdr_pkg::CFG_W-1:0] d,
  input  mdr_pkg::ctx_t             in_ctx,
  output logic                      out_v,
  output logic [63:0]               rem_o,
  output logic [63:0]               lo_o,
  output logic [63:0]               q_o,
  output mdr_pkg::ctx_t             out_ctx
);
  logic [64:0] sh;
  logic [64:0] diff;
  logic        take;
  always_comb begin
    sh   = {rem_i, lo_i[63]};
    diff = sh - {2'b00, d};
    take = !diff[64];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_v <= 1'b0;
    else if (en) out_v <= in_v;
    if (en) begin
      rem_o   <= take ? diff[63:0] : sh[63:0];
      lo_o    <= {lo_i[62:0], 1'b0};
      q_o     <= {q_i[62:0], take};
      out_ctx <= in_ctx;
    end
  end
endmodule

@@ hw/rtl/muldiv_rescale_with_rounding.sv @@
// Top level of the streaming scaled multiply-divide with rounding.
// Each beat on the input carries a signed 64-bit value; each output beat carries
// round(value*multiplier/divisor) and an error flag (result zero on error).
// The block is fully pipelined and takes one beat per clock while the output is not
// stalled. Its registers run in order: sign and magnitude, the partial products
// and their sum in the multiplier, the one-bit-per-stage restoring divider,
// rounding and the output register. The whole pipeline advances whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// Configuration must be written only while the pipeline is empty.
module muldiv_rescale_with_rounding (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[63:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // result[63:0]
  output logic        out_tuser,  // error
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_wdata
);
  localparam int NS = 64;

  logic [62:0] mult_r, div_r;
  logic [2:0]  mode_r;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= 63'd1;
      div_r  <= 63'd1;
      mode_r <= mdr_pkg::MODE_NEAREST;
    end else if (cfg_we) begin
      case (cfg_index)
        mdr_pkg::REG_MULT: mult_r <= cfg_wdata;
        mdr_pkg::REG_DIV:  div_r  <= cfg_wdata;
        mdr_pkg::REG_MODE: mode_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 0: sign, magnitude and configuration errors.
  logic          v0_r;
  logic [63:0]   mag0_r;
  mdr_pkg::ctx_t c0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
    if (en) begin
      c0_r.neg <= in_tdata[63];
      mag0_r   <= in_tdata[63] ? (~in_tdata + 64'd1) : in_tdata;
      c0_r.err <= (mult_r == '0) || (div_r == '0) || (mode_r > mdr_pkg::MODE_CEIL);
    end
  end

  logic          vm;
  logic [127:0]  prod;
  mdr_pkg::ctx_t cm;
  mdr_mul u_mul (.clk(clk), .rst_n(rst_n), .en(en), .in_v(v0_r), .mag(mag0_r),
    .mult(mult_r), .in_ctx(c0_r), .out_v(vm), .prod(prod), .out_ctx(cm));

  // Quotient overflow check folds into the context ahead of the divider.
  mdr_pkg::ctx_t cq;
  always_comb begin
    cq = cm;
    cq.err = cm.err || (prod[127:64] >= {1'b0, div_r});
  end

  logic          sv [NS+1];
  logic [63:0]   srem [NS+1];
  logic [63:0]   slo [NS+1];
  logic [63:0]   sq [NS+1];
  mdr_pkg::ctx_t sc [NS+1];
  assign sv[0] = vm;
  assign srem[0] = prod[127:64];
  assign slo[0] = prod[63:0];
  assign sq[0] = '0;
  assign sc[0] = cq;

  for (genvar i = 0; i < NS; i++) begin : g_div
    mdr_div_stage u_st (.clk(clk), .rst_n(rst_n), .en(en), .in_v(sv[i]),
      .rem_i(srem[i]), .lo_i(slo[i]), .q_i(sq[i]), .d(div_r), .in_ctx(sc[i]),
      .out_v(sv[i+1]), .rem_o(srem[i+1]), .lo_o(slo[i+1]), .q_o(sq[i+1]),
      .out_ctx(sc[i+1]));
  end

  // Rounding stage: decide the increment from mode, sign and remainder.
  logic [63:0]   rem, q;
  logic          inc, rnz, neg;
  logic [64:0]   qi;
  logic [64:0]   half;
  logic          rv_r, rerr_r, rneg_r;
  logic [64:0]   rq_r;
  assign rem = srem[NS];
  assign q   = sq[NS];
  assign neg = sc[NS].neg;
  assign rnz = rem != '0;
  assign half = {rem, 1'b0};
  always_comb begin
    case (mode_r)
      mdr_pkg::MODE_NEAREST: inc = half >= {2'b00, div_r};
      mdr_pkg::MODE_TRUNC:   inc = 1'b0;
      mdr_pkg::MODE_AWAY:    inc = rnz;
      mdr_pkg::MODE_FLOOR:   inc = neg && rnz;
      mdr_pkg::MODE_CEIL:    inc = !neg && rnz;
      default:               inc = 1'b0;
    endcase
    qi = {1'b0, q} + {64'd0, inc};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) rv_r <= 1'b0;
    else if (en) rv_r <= sv[NS];
    if (en) begin
      rq_r   <= qi;
      rneg_r <= neg;
      rerr_r <= sc[NS].err;
    end
  end

  // Output stage: range check against int64 and sign restore.
  logic ovf;
  assign ovf = rq_r[64] || (rneg_r ? (rq_r[63:0] > 64'h8000_0000_0000_0000) : rq_r[63]);
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= rv_r;
    if (en) begin
      out_tuser <= rerr_r || ovf;
      out_tdata <= (rerr_r || ovf) ? 64'd0 :
                   (rneg_r ? (~rq_r[63:0] + 64'd1) : rq_r[63:0]);
    end
  end
endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the streaming scaled multiply-divide with rounding.
`timescale 1ns / 100ps

module tb_top;

  // One expected output beat: the rounded quotient and the error flag.
  typedef struct {
    logic [63:0] result;
    logic        error;
  } rescaled_t;

  // Scoreboard: it holds its own copy of the registers, predicts each accepted input
  // beat and compares the output beats in order against those predictions.
  class rescale_scoreboard;
    logic [62:0] mult;
    logic [62:0] divr;
    logic [2:0]  mode;
    rescaled_t   pending[$];
    int          fails;

    function void reset_regs();
      mult = 63'd1;
      divr = 63'd1;
      mode = mdr_pkg::MODE_NEAREST;
    endfunction

    function void write_reg(logic [1:0] idx, logic [62:0] val);
      case (idx)
        mdr_pkg::REG_MULT: mult = val;
        mdr_pkg::REG_DIV:  divr = val;
        mdr_pkg::REG_MODE: mode = val[2:0];
        default: ;
      endcase
    endfunction

    // Rescale one value. Wide arithmetic stands in for the bit-per-stage divider pipeline.
    function rescaled_t rescale(logic [63:0] v);
      rescaled_t   o;
      logic        neg;
      logic [63:0] mag;
      logic [127:0] prod;
      logic [127:0] q;
      logic [127:0] r;
      logic        inc;
      neg = v[63];
      mag = neg ? -v : v;
      o.result = '0;
      o.error = 1'b1;
      if (mult == 0 || divr == 0) return o;
      prod = {64'd0, mag} * {65'd0, mult};
      // A quotient wider than 64 bits means the high half reaches the divisor.
      if (prod[127:64] >= {1'b0, divr}) return o;
      q = prod / {65'd0, divr};
      r = prod % {65'd0, divr};
      case (mode)
        mdr_pkg::MODE_NEAREST: inc = (r >= {65'd0, divr} - r);
        mdr_pkg::MODE_TRUNC:   inc = 1'b0;
        mdr_pkg::MODE_AWAY:    inc = (r != 0);
        mdr_pkg::MODE_FLOOR:   inc = neg && (r != 0);
        mdr_pkg::MODE_CEIL:    inc = !neg && (r != 0);
        default:               return o;
      endcase
      if (inc) begin
        if (q[63:0] == 64'hffff_ffff_ffff_ffff) return o;
        q = q + 128'd1;
      end
      if (neg) begin
        // The most negative result is exact, anything larger in magnitude overflows.
        if (q > 128'h8000_0000_0000_0000) return o;
        o.result = -q[63:0];
      end else begin
        if (q > 128'h7fff_ffff_ffff_ffff) return o;
        o.result = q[63:0];
      end
      o.error = 1'b0;
      return o;
    endfunction

    function void note_input(logic [63:0] v);
      pending.push_back(rescale(v));
    endfunction

    function void check_output(logic [63:0] res, logic err);
      rescaled_t e;
      if (pending.size() == 0) begin
        $error("output beat with nothing expected: result %h error %b", res, err);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (res !== e.result) begin
        $error("result: expected %h, actual %h", e.result, res);
        fails++;
      end
      if (err !== e.error) begin
        $error("error: expected %b, actual %b", e.error, err);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [62:0] cfg_wdata;

  rescale_scoreboard sb;
  // Values waiting to be offered on the input, in order.
  logic [63:0] value_queue[$];
  // Each increment asks the receiver for one long stretch of tready low.
  int          hold_reqs;
  bit          stall_on;

  localparam int PIPE_LAT = 69;
  localparam int HOLD_CYCLES = 200;

  muldiv_rescale_with_rounding DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sender: bursts of random length, mostly separated by random gaps. tvalid only drops
  // after an accepted beat, so a beat once offered stays stable until taken.
  initial begin : sender
    int burst;
    in_tvalid = 1'b0;
    in_tdata = '0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tdata);
        void'(value_queue.pop_front());
      end
      if (!rst_n || (in_tvalid && !in_tready)) continue;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      if (value_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= value_queue[0];
        burst--;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: its own stall pattern, with quiet stretches and long hold-offs
  // that it counts out itself.
  initial begin : receiver
    int phase;
    int hold_left;
    int hold_seen;
    out_tready = 1'b0;
    phase = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_output(out_tdata, out_tuser);
      phase++;
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end
      else if (!stall_on) out_tready <= 1'b1;
      else out_tready <= ((phase % 7) < 4) ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (phase % 300 == 0) stall_on = ~stall_on;
    end
  end

  // Random value: mostly small magnitudes so rounding matters, with some
  // extremes and fully random words.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
      2: v = -({{32{1'b0}}, $urandom} >> $urandom_range(0, 31));
      3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      4: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3))
                                 : 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 3));
      default: v = 64'($signed($urandom_range(0, 40)) - 20);
    endcase
    return v;
  endfunction

  function automatic logic [62:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return 63'($urandom_range(1, 16));
      1: return 63'($urandom);
      2: return 63'({$urandom, $urandom} >> $urandom_range(1, 40));
      default: return 63'({$urandom, $urandom} >> 1);
    endcase
  endfunction

  // Wait until every expected beat has come, then let the pipeline drain.
  task automatic wait_idle();
    while (value_queue.size() > 0 || in_tvalid || sb.pending.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [62:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic set_scale(logic [62:0] m, logic [62:0] d, logic [2:0] md);
    wait_idle();
    write_cfg(mdr_pkg::REG_MULT, m);
    write_cfg(mdr_pkg::REG_DIV, d);
    write_cfg(mdr_pkg::REG_MODE, md);
  endtask

  initial begin : stimulus
    sb = new();
    sb.reset_regs();
    sb.fails = 0;
    hold_reqs = 0;
    stall_on = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mdr_pkg::REG_MULT;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset scale: identity and extremes.
    value_queue.push_back(64'd0);
    value_queue.push_back(64'h7fff_ffff_ffff_ffff);
    value_queue.push_back(64'h8000_0000_0000_0000);
    value_queue.push_back(64'hffff_ffff_ffff_ffff);
    // Halves: every mode on +-5/2 and +-7/2.
    for (int md = 0; md < 5; md++) begin
      set_scale(63'd1, 63'd2, md[2:0]);
      value_queue.push_back(64'd5);
      value_queue.push_back(-64'sd5);
      value_queue.push_back(64'd7);
      value_queue.push_back(-64'sd7);
    end
    // Zero multiplier, zero divisor and a meaningless mode all flag an error.
    set_scale(63'd0, 63'd3, mdr_pkg::MODE_NEAREST);
    value_queue.push_back(64'd9);
    set_scale(63'd3, 63'd0, mdr_pkg::MODE_NEAREST);
    value_queue.push_back(64'd9);
    set_scale(63'd3, 63'd1, 3'd7);
    value_queue.push_back(64'd9);
    // Quotient too wide, and the most negative value landing exactly on -2^63.
    set_scale(63'h7fff_ffff_ffff_ffff, 63'd1, mdr_pkg::MODE_TRUNC);
    value_queue.push_back(64'd4);
    value_queue.push_back(64'd1);
    set_scale(63'd2, 63'd2, mdr_pkg::MODE_CEIL);
    value_queue.push_back(64'h8000_0000_0000_0000);
    // Rounding away from zero on a negative half.
    set_scale(63'd1, 63'd2, mdr_pkg::MODE_AWAY);
    value_queue.push_back(64'hffff_ffff_ffff_ffff);

    // Random phases, each with its own scale and mode.
    for (int ph = 0; ph < 13; ph++) begin
      logic [62:0] m;
      logic [62:0] d;
      m = (ph == 3) ? 63'h7fff_ffff_ffff_ffff : rand_scale();
      d = (ph == 5) ? 63'h7fff_ffff_ffff_ffff : rand_scale();
      if (ph == 8) m = 63'd0;
      set_scale(m, d, (ph == 11) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)));
      for (int k = 0; k < ((ph == 6) ? 110 : 45); k++) value_queue.push_back(rand_value());
      if (ph == 6) begin
        // Long hold-off on the output while the sender keeps offering.
        hold_reqs++;
      end
    end

    wait_idle();
    if (sb.fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
